### src/per_bin_erle_smoother_defines.svh
// ----------------------------------------------------------------------------
// per_bin_erle_smoother_defines.svh
// Assertion macros for the RTL of the ERLE smoother (per_bin_erle_smoother.sv).
// ----------------------------------------------------------------------------
`ifndef PER_BIN_ERLE_SMOOTHER_DEFINES_SVH
`define PER_BIN_ERLE_SMOOTHER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ERS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ERS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ERS_ASSERT_IMPL(label, ante, cons, msg)
`define ERS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### src/ers_pkg.sv
// ----------------------------------------------------------------------------
// ers_pkg
// Types, constants and helpers of the per-bin ERLE smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_DIVINIT,
        ST_DIV,
        ST_RATIO,
        ST_ALPHA,
        ST_MUL1,
        ST_MUL2,
        ST_SM1,
        ST_SM2,
        ST_PASS1,
        ST_PASS2
    } ers_state_t;

    typedef logic [1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_BINS = 2'd0;
    localparam cfg_addr_t CFG_RISE = 2'd1;
    localparam cfg_addr_t CFG_FALL = 2'd2;

    localparam logic [17:0] RATIO_MIN = 18'd26;
    localparam logic [17:0] RATIO_MAX = 18'd256000;
    localparam logic [17:0] ERLE_MIN  = 18'd128;
    localparam logic [17:0] ERLE_MAX  = 18'd51200;
    localparam logic [15:0] ERLE_ONE  = 16'd256;
    localparam logic [12:0] DT_ONE    = 13'd4096;
    localparam logic [16:0] ONE_Q16   = 17'h10000;

    localparam logic [9:0]  BINS_RST  = 10'd257;
    localparam logic [15:0] RISE_RST  = 16'd62259;
    localparam logic [15:0] FALL_RST  = 16'd45875;

    localparam int SQ_STEPS  = 24;
    localparam int DIV_STEPS = 18;

    // 1/4,1/2,1/4 kernel with rounding, then clip to 0.5..200
    function automatic logic [15:0] smooth3(input logic [17:0] l, input logic [17:0] m,
                                            input logic [17:0] r);
        logic [19:0] sum;
        logic [17:0] v;
        sum = 20'(l) + {1'b0, m, 1'b0} + 20'(r) + 20'd2;
        v = sum[19:2];
        if (v < ERLE_MIN) v = ERLE_MIN;
        if (v > ERLE_MAX) v = ERLE_MAX;
        return v[15:0];
    endfunction

    function automatic logic [23:0] mag24(input logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

endpackage

`default_nettype wire

### src/per_bin_erle_smoother.sv
// ----------------------------------------------------------------------------
// per_bin_erle_smoother
// Per-bin ERLE estimate: power ratio, asymmetric blend, 3-tap cross-bin
// smoothing, clipped write-back; results emitted one bin late.
// ----------------------------------------------------------------------------
//  channel   dir  beat fields
//  s_*       in   tdata: echo re/im, error re/im, dt level; tuser: far_end_active
//  m_*       out  tdata: bin_number, erle_value; tlast: frame_done
//  cfg_*     in   register writes, no handshake
//
//  Sequence: an active bin runs accept, 24 serial square steps, divider
//  setup, 18 divider steps, ratio, alpha, two multiply steps and smoothing,
//  with a further output step on the frame's last bin; an inactive bin
//  passes stored values through, with no output on bin 0.
//  Reset: a clearing pass over all MAX_BINS entries fills the store with 1.0;
//  s_tready stays low until it ends.
//  Stalls: a held m_tready keeps the sequencer waiting at its output step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_bin_erle_smoother_defines.svh"

module per_bin_erle_smoother #(
    parameter int MAX_BINS = 512
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input beats
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // [23:0] echo_real, [47:24] echo_imag, [71:48] error_real,
    // [95:72] error_imag, [111:96] doubletalk_level
    input  wire logic [111:0]     s_tdata,
    // [0] far_end_active
    input  wire logic             s_tuser,
    // result beats
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [8:0] bin_number, [24:9] erle_value, [31:25] zero
    output logic      [31:0]      m_tdata,
    output logic                  m_tlast,
    // config writes
    input  wire logic             cfg_wr_en,
    input  wire ers_pkg::cfg_addr_t cfg_addr,
    input  wire logic [15:0]      cfg_wr_data
);
    import ers_pkg::*;

    localparam int CW = $clog2(MAX_BINS);

    // config
    logic [9:0]  bins_reg;
    logic [15:0] rise_reg, fall_reg;

    // sequencer
    ers_state_t  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [CW-1:0] clr_reg;

    // per-frame state
    logic [CW-1:0] bin_cnt_reg;
    logic        frame_active_reg;
    logic [17:0] bp_reg, bbp_reg;

    // per-item context
    logic [CW-1:0] c_reg;
    logic        last_reg;

    // serial squaring
    logic [47:0] ea_mc_reg, eb_mc_reg, ra_mc_reg, rb_mc_reg;
    logic [23:0] ea_sr_reg, eb_sr_reg, ra_sr_reg, rb_sr_reg;
    logic [47:0] ep_reg, rp_reg;

    // serial divider
    logic [47:0] rem_reg;
    logic [17:0] q_reg;
    logic        sat_reg;

    // blend
    logic [12:0] dt_reg;
    logic [15:0] stored_reg;
    logic [17:0] ratio_reg;
    logic [16:0] alpha_reg;
    logic [32:0] prod_reg;
    logic [17:0] cur_reg;

    // output register
    logic        m_valid_reg;
    logic [8:0]  m_bin_reg;
    logic [15:0] m_val_reg;
    logic        m_last_reg;

    // RAM
    logic          ram_we, ram_re;
    logic [CW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    ers_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // combinational control
    // ------------------------------------------------------------------
    logic        accept, out_free, load_out;
    logic [8:0]  out_bin_n;
    logic [15:0] out_val_n;
    logic        out_last_n;
    logic        act_now, last_now;
    logic [15:0] nb16, c1_16;
    logic [15:0] v1, v2;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        // effective bin count, saturated to 2..MAX_BINS
        nb16 = {6'd0, bins_reg};
        if (nb16 < 16'd2) nb16 = 16'd2;
        if (nb16 > 16'(MAX_BINS)) nb16 = 16'(MAX_BINS);
        c1_16    = 16'(bin_cnt_reg) + 16'd1;
        last_now = (c1_16 >= nb16);
        act_now  = (bin_cnt_reg == '0) ? s_tuser : frame_active_reg;
    end

    assign v1 = smooth3(bbp_reg, bp_reg, cur_reg);
    assign v2 = smooth3(bbp_reg, bp_reg, 18'd0);

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        out_bin_n  = 9'd0;
        out_val_n  = 16'd0;
        out_last_n = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = c_reg;
        ram_wdata  = 16'd0;
        ram_re     = 1'b0;
        ram_raddr  = bin_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = ERLE_ONE;
                if (clr_reg == CW'(MAX_BINS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    ram_re    = 1'b1;
                    ram_raddr = act_now ? bin_cnt_reg : bin_cnt_reg - CW'(1);
                    if (act_now) state_next = ST_SQUARE;
                    else if (bin_cnt_reg != '0) state_next = ST_PASS1;
                end
            end
            ST_SQUARE: if (cnt_reg == 5'(SQ_STEPS - 1)) state_next = ST_DIVINIT;
            ST_DIVINIT: state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 5'(DIV_STEPS - 1)) state_next = ST_RATIO;
            ST_RATIO:  state_next = ST_ALPHA;
            ST_ALPHA:  state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_SM1;
            ST_SM1: begin
                if (c_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    out_bin_n  = 9'(16'(c_reg - CW'(1)));
                    out_val_n  = v1;
                    ram_we     = 1'b1;
                    ram_waddr  = c_reg - CW'(1);
                    ram_wdata  = v1;
                    state_next = last_reg ? ST_SM2 : ST_IDLE;
                end
            end
            ST_SM2: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_bin_n  = 9'(16'(c_reg));
                    out_val_n  = v2;
                    out_last_n = 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = c_reg;
                    ram_wdata  = v2;
                    state_next = ST_IDLE;
                end
            end
            ST_PASS1: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    out_bin_n = 9'(16'(c_reg - CW'(1)));
                    out_val_n = ram_rdata;
                    if (last_reg) begin
                        ram_re     = 1'b1;
                        ram_raddr  = c_reg;
                        state_next = ST_PASS2;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PASS2: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_bin_n  = 9'(16'(c_reg));
                    out_val_n  = ram_rdata;
                    out_last_n = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic [4:0]  div_k;
    logic [5:0]  div_idx;
    logic        div_bit, div_ge;
    logic [48:0] rem2;
    logic [17:0] ratio_n;
    logic [29:0] rise_prod;
    logic [17:0] rise_sum;
    logic [16:0] alpha_n;
    logic [35:0] blend_sum;
    logic [12:0] dt_n;
    logic signed [15:0] dt_in;

    always_comb begin
        div_k   = 5'(DIV_STEPS - 1) - cnt_reg;
        div_idx = 6'(div_k - 5'd8);
        div_bit = (div_k >= 5'd8) ? ep_reg[div_idx] : 1'b0;
        rem2    = {rem_reg, div_bit};
        div_ge  = (rem2 >= {1'b0, rp_reg});

        if (sat_reg || q_reg >= RATIO_MAX) ratio_n = RATIO_MAX;
        else if (q_reg < RATIO_MIN)        ratio_n = RATIO_MIN;
        else                               ratio_n = q_reg;

        rise_prod = 30'((ONE_Q16 - {1'b0, rise_reg}) * dt_reg);
        rise_sum  = {2'b0, rise_reg} + rise_prod[29:12];
        if (ratio_reg < {2'b0, stored_reg}) alpha_n = {1'b0, fall_reg};
        else                                alpha_n = rise_sum[16:0];

        blend_sum = 36'(prod_reg) + 36'((ONE_Q16 - alpha_reg) * ratio_reg) + 36'd32768;

        dt_in = s_tdata[111:96];
        if (dt_in < 0)                      dt_n = 13'd0;
        else if (dt_in > 16'sd4096)         dt_n = DT_ONE;
        else                                dt_n = dt_in[12:0];
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg         <= BINS_RST;
            rise_reg         <= RISE_RST;
            fall_reg         <= FALL_RST;
            cnt_reg          <= '0;
            clr_reg          <= '0;
            bin_cnt_reg      <= '0;
            frame_active_reg <= 1'b0;
            bp_reg           <= '0;
            bbp_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BINS: bins_reg <= cfg_wr_data[9:0];
                    CFG_RISE: rise_reg <= cfg_wr_data;
                    CFG_FALL: fall_reg <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + CW'(1);

            if (state_reg == ST_SQUARE || state_reg == ST_DIV) begin
                cnt_reg <= (state_next == state_reg) ? cnt_reg + 5'd1 : 5'd0;
            end else begin
                cnt_reg <= 5'd0;
            end

            if (accept) begin
                if (bin_cnt_reg == '0) frame_active_reg <= s_tuser;
                bin_cnt_reg <= last_now ? '0 : bin_cnt_reg + CW'(1);
            end

            if (state_reg == ST_SM1) begin
                if (c_reg == '0) begin
                    bbp_reg <= '0;
                    bp_reg  <= cur_reg;
                end else if (out_free) begin
                    bbp_reg <= bp_reg;
                    bp_reg  <= cur_reg;
                end
            end

            if (load_out)      m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            c_reg     <= bin_cnt_reg;
            last_reg  <= last_now;
            dt_reg    <= dt_n;
            ea_sr_reg <= mag24(s_tdata[23:0]);
            eb_sr_reg <= mag24(s_tdata[47:24]);
            ra_sr_reg <= mag24(s_tdata[71:48]);
            rb_sr_reg <= mag24(s_tdata[95:72]);
            ea_mc_reg <= {24'd0, mag24(s_tdata[23:0])};
            eb_mc_reg <= {24'd0, mag24(s_tdata[47:24])};
            ra_mc_reg <= {24'd0, mag24(s_tdata[71:48])};
            rb_mc_reg <= {24'd0, mag24(s_tdata[95:72])};
            ep_reg    <= '0;
            rp_reg    <= '0;
        end
        if (state_reg == ST_SQUARE) begin
            // one multiplier bit per cycle for each of the four squares
            ep_reg <= ep_reg + (ea_sr_reg[0] ? ea_mc_reg : 48'd0)
                             + (eb_sr_reg[0] ? eb_mc_reg : 48'd0);
            rp_reg <= rp_reg + (ra_sr_reg[0] ? ra_mc_reg : 48'd0)
                             + (rb_sr_reg[0] ? rb_mc_reg : 48'd0);
            ea_mc_reg <= ea_mc_reg << 1;
            eb_mc_reg <= eb_mc_reg << 1;
            ra_mc_reg <= ra_mc_reg << 1;
            rb_mc_reg <= rb_mc_reg << 1;
            ea_sr_reg <= ea_sr_reg >> 1;
            eb_sr_reg <= eb_sr_reg >> 1;
            ra_sr_reg <= ra_sr_reg >> 1;
            rb_sr_reg <= rb_sr_reg >> 1;
        end
        if (state_reg == ST_DIVINIT) begin
            // quotient of (ep<<8)/rp needs more than 18 bits: saturate
            sat_reg <= ({10'd0, ep_reg[47:10]} >= rp_reg);
            rem_reg <= {10'd0, ep_reg[47:10]};
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= div_ge ? 48'(rem2 - {1'b0, rp_reg}) : rem2[47:0];
            q_reg   <= {q_reg[16:0], div_ge};
        end
        if (state_reg == ST_RATIO) begin
            ratio_reg  <= ratio_n;
            stored_reg <= ram_rdata;
        end
        if (state_reg == ST_ALPHA) alpha_reg <= alpha_n;
        if (state_reg == ST_MUL1)  prod_reg  <= 33'(alpha_reg * stored_reg);
        if (state_reg == ST_MUL2)  cur_reg   <= blend_sum[33:16];
        if (load_out) begin
            m_bin_reg  <= out_bin_n;
            m_val_reg  <= out_val_n;
            m_last_reg <= out_last_n;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_val_reg, m_bin_reg};
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ERS_ASSERT_IMPL(a_no_overwrite, load_out && m_valid_reg, m_tready,
                     "result register overwritten while stalled")
    `ERS_ASSERT_IMPL(a_ratio_range, state_reg == ST_ALPHA,
                     ratio_reg >= RATIO_MIN && ratio_reg <= RATIO_MAX,
                     "ratio out of clip range")
    `ERS_ASSERT_IMPL(a_out_range, m_valid_reg && state_reg != ST_CLEAR,
                     m_val_reg >= 16'd128 && m_val_reg <= 16'd51200,
                     "emitted ERLE out of range")
    `ERS_ASSERT_NEXT(a_accept_leaves_idle, accept && act_now, state_reg == ST_SQUARE,
                     "active bin did not start squaring")

endmodule

`default_nettype wire

### src/ers_ram.sv
// ----------------------------------------------------------------------------
// ers_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_bin_erle_smoother: a directed table, then
// random frames under changing register settings, with random back-pressure.
// Every result beat is compared with a local model of the ERLE update.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ers_pkg::*;

    typedef struct {
        logic signed [23:0] echo_re, echo_im, err_re, err_im;
        logic               far;
        logic signed [15:0] dt;
    } bin_in_t;

    typedef struct {
        logic [8:0]  bin;
        logic [15:0] val;
        logic        done;
    } erle_out_t;

    // directed row: exp_first is the typed value of the first result it causes
    typedef struct {
        bin_in_t     it;
        bit          chk;
        logic [15:0] exp_first;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [31:0]  m_tdata;
    wire          m_tlast;
    logic         cfg_wr_en = 1'b0;
    cfg_addr_t    cfg_addr = CFG_BINS;
    logic [15:0]  cfg_wr_data = '0;

    per_bin_erle_smoother u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- model state ----------------
    logic [15:0] erle_mem [512];
    logic [9:0]  m_bins = BINS_RST;
    logic [15:0] m_rise = RISE_RST;
    logic [15:0] m_fall = FALL_RST;
    int unsigned m_bin_cnt = 0;
    longint unsigned m_prev = 0, m_prev2 = 0;
    bit          m_active = 0;

    erle_out_t   erle_expected [$];
    int          errors = 0;
    bit          quiet = 0;      // no idling in the closing part
    bit          hold_req = 0;   // ask the receiver for one long hold-off
    int          sent = 0;

    function automatic longint unsigned pow2(logic signed [23:0] a, logic signed [23:0] b);
        longint sa, sb;
        sa = a;
        sb = b;
        return longint'(sa * sa + sb * sb);
    endfunction

    function automatic longint unsigned kernel3(longint unsigned l, longint unsigned m,
                                                longint unsigned r);
        longint unsigned v;
        v = (l + 2 * m + r + 2) >> 2;
        if (v < 128) v = 128;
        if (v > 51200) v = 51200;
        return v;
    endfunction

    function automatic void push_result(int unsigned bin, longint unsigned val, bit done);
        erle_out_t e;
        e.bin = bin[8:0];
        e.val = val[15:0];
        e.done = done;
        erle_expected.push_back(e);
    endfunction

    // advance the model by one accepted bin
    function automatic void erle_update(bin_in_t it);
        int unsigned nb, c;
        bit last;
        longint unsigned ep, rp, ratio, stored, alpha, cur, v;
        longint dt;
        nb = m_bins;
        if (nb < 2) nb = 2;
        if (nb > 512) nb = 512;
        c = m_bin_cnt;
        if (c >= 512) c = 0;
        if (c == 0) m_active = it.far;
        last = (c + 1) >= nb;
        if (m_active) begin
            ep = pow2(it.echo_re, it.echo_im);
            rp = pow2(it.err_re, it.err_im);
            if (rp == 0 || ep >= rp * 1000) ratio = 256000;
            else begin
                ratio = (ep << 8) / rp;
                if (ratio < 26) ratio = 26;
            end
            dt = it.dt;
            if (dt < 0) dt = 0;
            if (dt > 4096) dt = 4096;
            stored = erle_mem[c];
            if (ratio < stored) alpha = m_fall;
            else alpha = m_rise + (((65536 - longint'(m_rise)) * dt) >> 12);
            cur = (alpha * stored + (65536 - alpha) * ratio + 32768) >> 16;
            if (c == 0) begin
                m_prev2 = 0;
                m_prev = cur;
            end else begin
                v = kernel3(m_prev2, m_prev, cur);
                erle_mem[c - 1] = v[15:0];
                push_result(c - 1, v, 0);
                m_prev2 = m_prev;
                m_prev = cur;
                if (last) begin
                    v = kernel3(m_prev2, cur, 0);
                    erle_mem[c] = v[15:0];
                    push_result(c, v, 1);
                end
            end
        end else if (c != 0) begin
            push_result(c - 1, erle_mem[c - 1], 0);
            if (last) push_result(c, erle_mem[c], 1);
        end
        m_bin_cnt = last ? 0 : c + 1;
    endfunction

    function automatic bin_in_t rand_bin();
        bin_in_t it;
        it.echo_re = 24'($urandom);
        it.echo_im = 24'($urandom);
        it.err_re = 24'($urandom);
        it.err_im = 24'($urandom);
        case ($urandom_range(0, 7))
            0: begin it.err_re = 0; it.err_im = 0; end              // zero error power
            1: begin it.echo_re = 0; it.echo_im = 0; end            // ratio floor
            2: begin                                                // tiny magnitudes
                it.echo_re = $signed(4'($urandom)); it.echo_im = $signed(4'($urandom));
                it.err_re = $signed(4'($urandom)); it.err_im = $signed(4'($urandom));
            end
            3: begin it.echo_re = $signed(12'($urandom)); it.echo_im = 0; end
            4: begin it.err_re = $signed(12'($urandom)); it.err_im = 0; end
            default: ;
        endcase
        it.far = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
            0: it.dt = 16'($urandom);
            1: it.dt = $urandom_range(0, 1) ? 16'sd0 : 16'sd4096;
            default: it.dt = 16'($urandom_range(0, 4096));
        endcase
        return it;
    endfunction

    function automatic dir_row_t row(int er, int ei, int rr, int ri, bit far, int dt,
                                     bit chk = 0, int exp_first = 0);
        dir_row_t r;
        r.it.echo_re = 24'(er); r.it.echo_im = 24'(ei);
        r.it.err_re = 24'(rr); r.it.err_im = 24'(ri);
        r.it.far = far; r.it.dt = 16'(dt);
        r.chk = chk; r.exp_first = 16'(exp_first);
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic cfg_write(cfg_addr_t a, logic [15:0] d);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = a;
        cfg_wr_data = d;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (a)
            CFG_BINS: m_bins = d[9:0];
            CFG_RISE: m_rise = d;
            CFG_FALL: m_fall = d;
            default: ;
        endcase
    endtask

    // one input beat; returns once accepted, inputs left at the falling edge
    task automatic send_bin(bin_in_t it, bit chk = 0, logic [15:0] exp_first = 0);
        int base;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tdata = {it.dt, it.err_im, it.err_re, it.echo_im, it.echo_re};
        s_tuser = it.far;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        base = erle_expected.size();
        erle_update(it);
        if (chk && (erle_expected.size() <= base || erle_expected[base].val != exp_first)) begin
            errors++;
            $display("%0t directed: expected erle %0d, model gives %0d", $time, exp_first,
                     erle_expected.size() > base ? erle_expected[base].val : 16'hx);
        end
        sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // wait until every result is in, then cover the latency of a bin with no result
    task automatic drain();
        while (erle_expected.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // receiver: random ready bursts plus one long hold-off on request
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (600) @(negedge aclk);
                hold_req = 0;
            end
            if (gap > 0) begin
                gap--;
                m_tready = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11) - 1;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        erle_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (erle_expected.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: bin %0d erle %0d last %0b", $time,
                         m_tdata[8:0], m_tdata[24:9], m_tlast);
            end else begin
                e = erle_expected.pop_front();
                if (m_tdata[8:0] !== e.bin) begin
                    errors++;
                    $display("%0t bin_number: expected %0d, got %0d", $time, e.bin, m_tdata[8:0]);
                end
                if (m_tdata[24:9] !== e.val) begin
                    errors++;
                    $display("%0t erle_value: expected %0d, got %0d", $time, e.val,
                             m_tdata[24:9]);
                end
                if (m_tlast !== e.done) begin
                    errors++;
                    $display("%0t frame_done: expected %0b, got %0b", $time, e.done, m_tlast);
                end
            end
        end
    end

    // hard limit on the run
    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin
        dir_row_t tbl [$];
        int nb;
        for (int i = 0; i < 512; i++) erle_mem[i] = ERLE_ONE;

        // two-bin frames make every edge case visible quickly
        tbl.push_back(row(1000, 0, 1000, 0, 0, 0));                    // inactive frame
        tbl.push_back(row(5, 5, 5, 5, 0, 0, 1, 256));                  // stored 1.0 passes
        tbl.push_back(row(8388607, 8388607, 0, 0, 1, 0));              // zero error power
        tbl.push_back(row(-8388608, -8388608, 0, 0, 1, 4096));
        tbl.push_back(row(0, 0, 8388607, -8388608, 1, -32768));        // ratio floor
        tbl.push_back(row(0, 0, -8388608, 8388607, 1, 32767));
        tbl.push_back(row(-8388608, 8388607, 8388607, -8388608, 1, 2048));
        tbl.push_back(row(1, -1, 1, 1, 1, 1));
        tbl.push_back(row(100, 0, 1, 0, 1, 4095));
        tbl.push_back(row(1, 0, 100, 0, 1, -1));
        tbl.push_back(row(7, 3, 0, 0, 0, 0));                          // inactive again
        tbl.push_back(row(7, 3, 0, 0, 1, 0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        cfg_write(CFG_BINS, 16'd2);
        foreach (tbl[i]) send_bin(tbl[i].it, tbl[i].chk, tbl[i].exp_first);
        drain();

        // factor extremes
        cfg_write(CFG_RISE, 16'd0);
        cfg_write(CFG_FALL, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_bin(row(3000 * i, 17, 200, -9, 1, 1024 * i).it);
        drain();
        cfg_write(CFG_RISE, 16'hFFFF);
        cfg_write(CFG_FALL, 16'd0);
        for (int i = 0; i < 4; i++) send_bin(row(-50, 9000 * i, 300, 1, 1, 0).it);
        drain();

        // count below range saturates to two bins
        cfg_write(CFG_BINS, 16'd1);
        for (int i = 0; i < 4; i++) send_bin(rand_bin());
        drain();

        // bin count lowered in the middle of a frame ends it early
        cfg_write(CFG_BINS, 16'd6);
        for (int i = 0; i < 4; i++) send_bin(row(400, i, 20, 3, 1, 100).it);
        drain();
        cfg_write(CFG_BINS, 16'd2);
        send_bin(row(400, 9, 20, 3, 1, 100).it);
        drain();

        // random phases with small frames
        for (int ph = 0; sent < 360; ph++) begin
            if (ph == 3) hold_req = 1;                  // block fills and stalls input
            nb = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
            cfg_write(CFG_BINS, 16'(nb));
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_RISE, $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
                default: cfg_write(CFG_RISE, 16'($urandom));
            endcase
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_FALL, $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
                default: cfg_write(CFG_FALL, 16'($urandom));
            endcase
            repeat ($urandom_range(2, 6) * nb + $urandom_range(0, 1)) send_bin(rand_bin());
            drain();
        end

        // one full-size frame, count above range saturates to the maximum
        cfg_write(CFG_BINS, 16'h03FF);
        cfg_write(CFG_RISE, RISE_RST);
        cfg_write(CFG_FALL, FALL_RST);
        repeat (512) send_bin(rand_bin());
        drain();

        // closing part without idling on either side
        quiet = 1;
        cfg_write(CFG_BINS, 16'd5);
        repeat (60) send_bin(rand_bin());
        drain();

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
